FILE: hw/rtl/hsc_pkg.sv
`default_nettype none
package hsc_pkg;

  typedef struct packed {
    logic signed [19:0] hip_x;
    logic signed [19:0] hip_y;
    logic signed [19:0] hip_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [19:0] ball_x;
    logic signed [19:0] ball_y;
    logic signed [19:0] ball_z;
    logic               in_contact;
  } out_t;

  typedef struct packed {
    logic [17:0] half_side;
    logic [15:0] hip_radius;
    logic [15:0] ball_radius;
    logic [23:0] probe_wall_k;
    logic [23:0] ball_wall_k;
    logic [23:0] contact_k;
    logic [31:0] damping;
    logic [23:0] inv_mass;
  } cfg_t;

  localparam int CFG_IDX_W  = 4;
  localparam int DIV_STEPS  = 58;
  localparam int SQRT_STEPS = 31;
  localparam int DT_STEPS   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_SIDE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIP_RADIUS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BALL_RADIUS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_WALL_K = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BALL_WALL_K  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_K    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS     = 4'd7;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQ,
    OP_WH,
    OP_WB,
    OP_RT_INIT,
    OP_RT_STEP,
    OP_CMUL,
    OP_DIV_STEP,
    OP_CFC,
    OP_D1,
    OP_D2,
    OP_D3,
    OP_ACC,
    OP_DT_STEP,
    OP_VUPD,
    OP_PUPD,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic contact_nz;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/hsc_cfg.sv
`default_nettype none
module hsc_cfg import hsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_side    <= 18'd16640;
      cfg.hip_radius   <= 16'd1280;
      cfg.ball_radius  <= 16'd2560;
      cfg.probe_wall_k <= 24'd31457;
      cfg.ball_wall_k  <= 24'd262144;
      cfg.contact_k    <= 24'd31457;
      cfg.damping      <= 32'd33554;
      cfg.inv_mass     <= 24'd51200;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HALF_SIDE:    cfg.half_side    <= cfg_data[17:0];
        REG_HIP_RADIUS:   cfg.hip_radius   <= cfg_data[15:0];
        REG_BALL_RADIUS:  cfg.ball_radius  <= cfg_data[15:0];
        REG_PROBE_WALL_K: cfg.probe_wall_k <= cfg_data[23:0];
        REG_BALL_WALL_K:  cfg.ball_wall_k  <= cfg_data[23:0];
        REG_CONTACT_K:    cfg.contact_k    <= cfg_data[23:0];
        REG_DAMPING:      cfg.damping      <= cfg_data;
        REG_INV_MASS:     cfg.inv_mass     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/hsc_div.sv
`default_nettype none
module hsc_div import hsc_pkg::*; (
  input  logic               clk,
  input  logic               start,
  input  logic               step,
  input  logic [57:0]        mag,
  input  logic               neg,
  input  logic [22:0]        den,
  output logic signed [58:0] quo
);

  // restoring divider, one quotient bit per step; quotient shifts in at the bottom of num
  logic [22:0] rem;
  logic [57:0] num;
  logic        neg_r;
  logic [22:0] den_r;
  logic [23:0] trial;
  logic        qbit;

  assign trial = {rem, num[57]};
  assign qbit  = (trial >= {1'b0, den_r});
  assign quo   = neg_r ? -$signed({1'b0, num}) : $signed({1'b0, num});

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      num   <= mag;
      neg_r <= neg;
      den_r <= den;
    end else if (step) begin
      rem <= qbit ? 23'(trial - {1'b0, den_r}) : trial[22:0];
      num <= {num[56:0], qbit};
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/hsc_dp.sv
`default_nettype none
module hsc_dp import hsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  cfg_t cfg,
  input  in_t  in_data,
  output sts_t sts,
  output out_t out_data
);

  localparam logic signed [55:0] FS_MAX   = 56'sd274877906943;
  // divide by 1000 ticks per second: radix 2^16 long division, each digit taken by
  // multiplying with ceil(2^36/1000), exact for partial remainders below 2^26
  localparam logic [26:0]        DT_RECIP = 27'd68719477;
  localparam logic [9:0]         DT_DIV   = 10'd1000;

  logic signed [19:0] hip [3];
  logic signed [47:0] pos [3];
  logic signed [47:0] vel [3];
  logic signed [55:0] fp  [3];
  logic signed [55:0] fs  [3];
  logic [49:0]        sum;
  logic [61:0]        rt_n, rt_res, rt_bit;
  logic signed [63:0] p1;
  logic signed [56:0] p2;
  logic [55:0]        p3;
  out_t               res;

  function automatic logic signed [26:0] pen(input logic signed [26:0] p,
                                             input logic [15:0] r, input logic [17:0] hs);
    logic signed [26:0] rs, hss, t;
    rs  = $signed({11'd0, r});
    hss = $signed({9'd0, hs});
    t   = '0;
    if (p + rs > hss) t = t + (hss - p - rs);
    if (p - rs < -hss) t = t + (-hss - p + rs);
    return t;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [59:0] v);
    if (v[59:47] == {13{v[59]}}) return v[47:0];
    return v[59] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v[47:31] == {17{v[47]}}) return v[31:0];
    return v[47] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
    if (v[23:19] == {5{v[23]}}) return v[19:0];
    return v[23] ? {1'b1, 19'd0} : {1'b0, {19{1'b1}}};
  endfunction

  // per-axis geometry from the sphere position held at the start of the tick
  logic [1:0]         a;
  logic signed [19:0] hip_a;
  logic signed [23:0] ball_a;
  logic signed [24:0] d_a;
  logic signed [49:0] sq;
  logic signed [26:0] pen_h, pen_b;
  logic signed [51:0] wh_prod, wb_prod;

  assign a       = cmd.axis;
  assign hip_a   = hip[a];
  assign ball_a  = pos[a][47:24];
  assign d_a     = {ball_a[23], ball_a} - {{5{hip_a[19]}}, hip_a};
  assign sq      = d_a * d_a;
  assign pen_h   = pen({{7{hip_a[19]}}, hip_a}, cfg.hip_radius, cfg.half_side);
  assign pen_b   = pen({{3{ball_a[23]}}, ball_a}, cfg.ball_radius, cfg.half_side);
  assign wh_prod = pen_h * $signed({1'b0, cfg.probe_wall_k});
  assign wb_prod = pen_b * $signed({1'b0, cfg.ball_wall_k});

  // contact test
  logic [30:0]        cdist;
  logic [16:0]        rsum;
  logic signed [32:0] delta;
  logic               contact;
  logic [62:0]        rt_t;

  assign cdist   = rt_res[30:0];
  assign rsum    = {1'b0, cfg.hip_radius} + {1'b0, cfg.ball_radius};
  assign delta   = $signed({2'b0, cdist}) - $signed({10'd0, rsum, 6'd0});
  assign contact = delta[32];
  assign sts.contact_nz = contact && (cdist != 31'd0);
  assign rt_t    = {1'b0, rt_res} + {1'b0, rt_bit};

  // numerators for the dividers
  logic signed [48:0] cm;
  logic signed [54:0] cnum;
  logic [54:0]        cmag;
  logic signed [38:0] fsat;
  logic signed [57:0] damp;
  logic signed [58:0] acc;
  logic signed [58:0] amag;
  logic signed [58:0] quo;
  logic signed [47:0] v_new, p_new;
  logic signed [55:0] vnum;
  logic [55:0]        vmag;
  logic signed [25:0] qc;
  logic signed [49:0] fcp;
  logic signed [55:0] fc;

  logic               dv_start, dv_step;
  logic               dt_start, dt_neg, dt_neg_r;
  logic [63:0]        dt_mag, dt_num;
  logic [9:0]         dt_rem;
  logic [25:0]        dt_x, dt_back;
  logic [52:0]        dt_prod;
  logic [15:0]        dt_digit;
  logic signed [58:0] dt_quo;

  assign cm   = $signed(delta[23:0]) * d_a;
  assign cnum = {cm, 6'd0};
  assign cmag = cnum[54] ? 55'(-cnum) : 55'(cnum);

  always_comb begin
    if (fs[a] > FS_MAX) fsat = FS_MAX[38:0];
    else if (fs[a] < -FS_MAX) fsat = 39'(-FS_MAX);
    else fsat = fs[a][38:0];
  end

  assign damp  = {p2[56], p2} + {26'd0, p3[55:24]};
  assign acc   = {{3{p1[63]}}, p1[63:8]} - {damp[57], damp};
  assign amag  = acc[58] ? -acc : acc;
  assign v_new = sat48({{12{vel[a][47]}}, vel[a]} + {dt_quo[58], dt_quo});
  assign p_new = sat48({{12{pos[a][47]}}, pos[a]} + {dt_quo[58], dt_quo});
  assign vnum  = {v_new, 8'd0};
  assign vmag  = vnum[55] ? 56'(-vnum) : 56'(vnum);
  assign qc    = quo[25:0];
  assign fcp   = qc * $signed({1'b0, cfg.contact_k});
  assign fc    = {{12{fcp[49]}}, fcp[49:6]};

  assign dv_start = (cmd.op == OP_CMUL);
  assign dv_step  = (cmd.op == OP_DIV_STEP);

  hsc_div u_div (
    .clk   (clk),
    .start (dv_start),
    .step  (dv_step),
    .mag   ({3'd0, cmag}),
    .neg   (cnum[54]),
    .den   (cdist[22:0]),
    .quo   (quo)
  );

  always_comb begin
    dt_start = 1'b0;
    dt_neg   = 1'b0;
    dt_mag   = '0;
    case (cmd.op)
      OP_ACC: begin
        dt_start = 1'b1;
        dt_neg   = acc[58];
        dt_mag   = {6'd0, amag[57:0]};
      end
      OP_VUPD: begin
        dt_start = 1'b1;
        dt_neg   = vnum[55];
        dt_mag   = {8'd0, vmag};
      end
      default: ;
    endcase
  end

  assign dt_x     = {dt_rem, dt_num[63:48]};
  assign dt_prod  = dt_x * DT_RECIP;
  assign dt_digit = dt_prod[51:36];
  assign dt_back  = {10'd0, dt_digit} * {16'd0, DT_DIV};
  assign dt_quo   = dt_neg_r ? -$signed({1'b0, dt_num[57:0]}) : $signed({1'b0, dt_num[57:0]});

  always_ff @(posedge clk) begin
    if (dt_start) begin
      dt_num   <= dt_mag;
      dt_rem   <= '0;
      dt_neg_r <= dt_neg;
    end else if (cmd.op == OP_DT_STEP) begin
      dt_num <= {dt_num[47:0], dt_digit};
      dt_rem <= 10'(dt_x - dt_back);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_VUPD: vel[a] <= v_new;
        OP_PUPD: pos[a] <= p_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        hip[0] <= in_data.hip_x;
        hip[1] <= in_data.hip_y;
        hip[2] <= in_data.hip_z;
        sum    <= '0;
      end
      OP_SQ: sum   <= sum + {2'd0, sq[47:0]};
      OP_WH: fp[a] <= {{4{wh_prod[51]}}, wh_prod};
      OP_WB: fs[a] <= {{4{wb_prod[51]}}, wb_prod};
      OP_RT_INIT: begin
        rt_n   <= {sum, 12'd0};
        rt_res <= '0;
        rt_bit <= 62'd1 << 60;
      end
      OP_RT_STEP: begin
        if ({1'b0, rt_n} >= rt_t) begin
          rt_n   <= 62'({1'b0, rt_n} - rt_t);
          rt_res <= (rt_res >> 1) + rt_bit;
        end else begin
          rt_res <= rt_res >> 1;
        end
        rt_bit <= rt_bit >> 2;
      end
      OP_CFC: begin
        fp[a] <= fp[a] - fc;
        fs[a] <= fs[a] + fc;
      end
      OP_D1: p1 <= fsat * $signed({1'b0, cfg.inv_mass});
      OP_D2: p2 <= $signed({1'b0, cfg.damping}) * $signed(vel[a][47:24]);
      OP_D3: p3 <= cfg.damping * vel[a][23:0];
      OP_OUT: begin
        res.force_x    <= sat32(fp[0][55:8]);
        res.force_y    <= sat32(fp[1][55:8]);
        res.force_z    <= sat32(fp[2][55:8]);
        res.ball_x     <= sat20(pos[0][47:24]);
        res.ball_y     <= sat20(pos[1][47:24]);
        res.ball_z     <= sat20(pos[2][47:24]);
        res.in_contact <= contact;
      end
      default: ;
    endcase
  end

  assign out_data = res;

endmodule
`default_nettype wire

FILE: hw/rtl/hsc_ctrl.sv
`default_nettype none
module hsc_ctrl import hsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_SQ      = 18'h00002,
    S_WH      = 18'h00004,
    S_WB      = 18'h00008,
    S_RT_INIT = 18'h00010,
    S_RT      = 18'h00020,
    S_CMUL    = 18'h00040,
    S_CDIV    = 18'h00080,
    S_CFC     = 18'h00100,
    S_D1      = 18'h00200,
    S_D2      = 18'h00400,
    S_D3      = 18'h00800,
    S_ACC     = 18'h01000,
    S_ADIV    = 18'h02000,
    S_VUPD    = 18'h04000,
    S_PDIV    = 18'h08000,
    S_PUPD    = 18'h10000,
    S_OUT     = 18'h20000
  } state_t;

  localparam logic [5:0] DIV_LAST  = 6'(DIV_STEPS - 1);
  localparam logic [5:0] SQRT_LAST = 6'(SQRT_STEPS - 1);
  localparam logic [5:0] DT_LAST   = 6'(DT_STEPS - 1);
  localparam logic [1:0] AXIS_LAST = 2'd2;

  state_t     state, state_next;
  logic [1:0] axis, axis_next;
  logic [5:0] cnt, cnt_next;
  logic       out_valid_next;
  logic       last_axis;

  assign in_stall  = (state != S_IDLE);
  assign last_axis = (axis == AXIS_LAST);
  assign cmd.axis  = axis;

  always_comb begin
    state_next     = state;
    axis_next      = axis;
    cnt_next       = cnt;
    cmd.op         = OP_NOP;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          axis_next  = '0;
          state_next = S_SQ;
        end
      end
      S_SQ, S_WH, S_WB: begin
        cmd.op    = (state == S_SQ) ? OP_SQ : (state == S_WH) ? OP_WH : OP_WB;
        axis_next = last_axis ? 2'd0 : axis + 2'd1;
        if (last_axis) begin
          state_next = (state == S_SQ) ? S_WH : (state == S_WH) ? S_WB : S_RT_INIT;
        end
      end
      S_RT_INIT: begin
        cmd.op     = OP_RT_INIT;
        cnt_next   = '0;
        state_next = S_RT;
      end
      S_RT: begin
        cmd.op   = OP_RT_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == SQRT_LAST) state_next = S_CMUL;
      end
      S_CMUL: begin
        // no overlap or coincident centers: contact force is zero, go straight to the dynamics
        if (sts.contact_nz) begin
          cmd.op     = OP_CMUL;
          cnt_next   = '0;
          state_next = S_CDIV;
        end else begin
          axis_next  = '0;
          state_next = S_D1;
        end
      end
      S_CDIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == DIV_LAST) state_next = S_CFC;
      end
      S_CFC: begin
        cmd.op     = OP_CFC;
        axis_next  = last_axis ? 2'd0 : axis + 2'd1;
        state_next = last_axis ? S_D1 : S_CMUL;
      end
      S_D1: begin
        cmd.op     = OP_D1;
        state_next = S_D2;
      end
      S_D2: begin
        cmd.op     = OP_D2;
        state_next = S_D3;
      end
      S_D3: begin
        cmd.op     = OP_D3;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = OP_ACC;
        cnt_next   = '0;
        state_next = S_ADIV;
      end
      S_ADIV: begin
        cmd.op   = OP_DT_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == DT_LAST) state_next = S_VUPD;
      end
      S_VUPD: begin
        cmd.op     = OP_VUPD;
        cnt_next   = '0;
        state_next = S_PDIV;
      end
      S_PDIV: begin
        cmd.op   = OP_DT_STEP;
        cnt_next = cnt + 6'd1;
        if (cnt == DT_LAST) state_next = S_PUPD;
      end
      S_PUPD: begin
        cmd.op     = OP_PUPD;
        axis_next  = last_axis ? 2'd0 : axis + 2'd1;
        state_next = last_axis ? S_OUT : S_D1;
      end
      S_OUT: begin
        // the result register is reloaded only once the previous result has been transferred
        if (!out_valid || !out_stall) begin
          cmd.op         = OP_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_SQ && axis == 2'd0)
    else $error("accepted item did not start the geometry pass");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output step");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    axis != 2'd3)
    else $error("axis counter out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |-> !out_valid || !out_stall)
    else $error("pending result overwritten");

endmodule
`default_nettype wire

FILE: hw/rtl/haptic_sphere_contact_step.sv
// One haptic tick per input transfer: probe position in, probe force, free sphere position and
// contact flag out. Items are processed one at a time; in_stall stays high from the transfer of
// a tick until its result is loaded into the output register. The output step waits while an
// earlier result is still pending. The length of a tick is set by the bit-serial divider used
// once per axis for the contact force, the square root of the center distance, and two
// divisions by the tick rate per axis in the Euler step. The result register holds a finished
// result while the next tick runs. Configuration writes are always ready and must be made only
// while no tick is in flight. The sphere starts at rest at the cube center.
`default_nettype none
module haptic_sphere_contact_step import hsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  hsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hsc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
